FILE: src/sfet_pkg.sv
// ----------------------------------------------------------------------------
// sfet_pkg
// Shared types and codes for the sorted free extent table.
// ----------------------------------------------------------------------------
package sfet_pkg;

  // Default sizing
  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_ADDR_BITS   = 16;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_FREE   = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_WRITE  = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // Update command broadcast to every cell of the row
  typedef enum logic [2:0] {
    UPD_NONE      = 3'd0,
    UPD_INSERT    = 3'd1,  // load at pos, cells above take their left neighbor
    UPD_SET       = 3'd2,  // load start and size at pos
    UPD_SIZE      = 3'd3,  // load size at pos
    UPD_SIZE_PULL = 3'd4,  // load size at pos, cells above take their right neighbor
    UPD_REMOVE    = 3'd5   // cells at and above pos take their right neighbor
  } upd_mode_t;

  // Per-cell search flags
  typedef struct packed {
    logic lt;        // valid and start below the key
    logic last_lt;   // highest cell with lt set
    logic succ_hit;  // sits at the insert point and starts where the key ends
    logic pred_hit;  // highest lt cell and ends where the key starts
  } cell_flags_t;

endpackage

FILE: src/sfet_req_if.sv
// ----------------------------------------------------------------------------
// sfet_req_if
// Request channel: valid/ready handshake with one operation per beat.
// ----------------------------------------------------------------------------
interface sfet_req_if #(
  parameter int ADDR_BITS = 16,
  parameter int IDX_W     = 6
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic [ADDR_BITS-1:0] extent_start;
  logic [ADDR_BITS:0]   extent_size;
  logic [IDX_W-1:0]     entry_index;

  modport source (
    output valid, func, extent_start, extent_size, entry_index,
    input  ready
  );
  modport sink (
    input  valid, func, extent_start, extent_size, entry_index,
    output ready
  );
endinterface

FILE: src/sfet_rsp_if.sv
// ----------------------------------------------------------------------------
// sfet_rsp_if
// Response channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface sfet_rsp_if #(
  parameter int ADDR_BITS = 16,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [IDX_W-1:0]     result_index;
  logic [CNT_W-1:0]     entry_count;
  logic                 merged_next;
  logic                 merged_prev;
  logic [ADDR_BITS-1:0] read_start;
  logic [ADDR_BITS:0]   read_size;

  modport source (
    output valid, status, result_index, entry_count, merged_next, merged_prev,
           read_start, read_size,
    input  ready
  );
  modport sink (
    input  valid, status, result_index, entry_count, merged_next, merged_prev,
           read_start, read_size,
    output ready
  );
endinterface

FILE: src/sorted_free_extent_table_core.sv
// ----------------------------------------------------------------------------
// sorted_free_extent_table_core
// Address-ordered free extent table with coalescing, built as a row of
// entry cells that shift toward or away from an insert or remove point.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      beat contents
//  req      in   valid/ready    func, extent_start, extent_size, entry_index
//  rsp      out  valid/ready    status, result_index, entry_count,
//                               merged_next, merged_prev, read_start, read_size
//
//  An operation is a search, then an update: the accept cycle runs the search
//  in all cells at once and registers its results; the update cycle in
//  S_FINISH applies the shift or merge to the row and loads the response register.
//  req.ready is high while no operation is in flight, also while a response
//  waits; the update cycle holds while the response register is still full.
//  rst is synchronous and clears the entry count, sequencer and response valid.
//  Entry contents are not reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_free_extent_table_core
  import sfet_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst,
  sfet_req_if.sink    req,
  sfet_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SZ_W  = ADDR_BITS + 1;
  localparam int LVLS  = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_FINISH = 2'b10
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic                 accept, fin;

  // operation registers captured at accept
  func_t                op_func;
  logic [ADDR_BITS-1:0] op_start;
  logic [SZ_W-1:0]      op_size;
  logic [IDX_W-1:0]     op_idx;
  logic                 full, bad, nx, pv;
  logic [IDX_W-1:0]     pos;
  logic [SZ_W-1:0]      nsum;
  logic [ADDR_BITS-1:0] pred_start;
  logic [SZ_W-1:0]      pred_size;

  // row wiring
  logic [ADDR_BITS-1:0] cell_start      [TABLE_DEPTH];
  logic [SZ_W-1:0]      cell_size       [TABLE_DEPTH];
  cell_flags_t          cell_flags      [TABLE_DEPTH];
  logic [SZ_W-1:0]      cell_mrg_size   [TABLE_DEPTH];
  logic [ADDR_BITS-1:0] cell_pred_start [TABLE_DEPTH];
  logic [SZ_W-1:0]      cell_pred_size  [TABLE_DEPTH];
  logic [ADDR_BITS-1:0] cell_rd_start   [TABLE_DEPTH];
  logic [SZ_W-1:0]      cell_rd_size    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_vec;
  logic [TABLE_DEPTH-1:0] sfx [LVLS+1];

  // reduced search results
  logic                 nx_c, pv_c;
  logic [IDX_W:0]       pos_c;
  logic [SZ_W-1:0]      mrg_c, pred_size_c, rd_size_c;
  logic [ADDR_BITS-1:0] pred_start_c, rd_start_c;

  // update command
  upd_mode_t            mode_c, upd_mode;
  logic [IDX_W-1:0]     upd_pos;
  logic [ADDR_BITS-1:0] upd_start;
  logic [SZ_W-1:0]      upd_size;
  logic [IDX_W:0]       rd_idx;
  logic [SZ_W:0]        pred_grow;
  logic [SZ_W-1:0]      pred_total;

  // response register
  logic                 out_valid;
  status_t              r_status, out_status;
  logic [IDX_W-1:0]     r_idx, out_idx;
  logic                 r_nx, r_pv, out_nx, out_pv;
  logic [ADDR_BITS-1:0] r_start, out_start;
  logic [SZ_W-1:0]      r_size, out_size;
  logic [CNT_W-1:0]     out_cnt;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fin       = (state == S_FINISH) && (!out_valid || rsp.ready);
  assign upd_mode  = fin ? mode_c : UPD_NONE;

  // Row of entry cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                 lt_left, tail_lt;
    logic [ADDR_BITS-1:0] l_start, r_start_n;
    logic [SZ_W-1:0]      l_size, r_size_n;

    if (g == 0) begin : g_first
      assign lt_left = 1'b1;
      assign l_start = cell_start[g];
      assign l_size  = cell_size[g];
    end else begin : g_mid_l
      assign lt_left = lt_vec[g-1];
      assign l_start = cell_start[g-1];
      assign l_size  = cell_size[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign tail_lt   = 1'b0;
      assign r_start_n = cell_start[g];
      assign r_size_n  = cell_size[g];
    end else begin : g_mid_r
      assign tail_lt   = sfx[LVLS][g+1];
      assign r_start_n = cell_start[g+1];
      assign r_size_n  = cell_size[g+1];
    end

    sfet_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_BITS   (ADDR_BITS),
      .CELL_INDEX  (g)
    ) u_cell (
      .clk         (clk),
      .count       (cnt),
      .key_start   (req.extent_start),
      .key_size    (req.extent_size),
      .lt_left     (lt_left),
      .tail_lt     (tail_lt),
      .upd_mode    (upd_mode),
      .upd_pos     (upd_pos),
      .upd_start   (upd_start),
      .upd_size    (upd_size),
      .left_start  (l_start),
      .left_size   (l_size),
      .right_start (r_start_n),
      .right_size  (r_size_n),
      .rd_idx      (rd_idx),
      .start       (cell_start[g]),
      .size        (cell_size[g]),
      .below_key   (lt_vec[g]),
      .flags       (cell_flags[g]),
      .mrg_size    (cell_mrg_size[g]),
      .pred_start  (cell_pred_start[g]),
      .pred_size   (cell_pred_size[g]),
      .rd_start    (cell_rd_start[g]),
      .rd_size     (cell_rd_size[g])
    );
  end

  // Suffix OR of lt over the row, log-depth
  always_comb begin
    sfx[0] = lt_vec;
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        sfx[l+1][i] = sfx[l][i];
        if (i + (1 << l) < TABLE_DEPTH) begin
          sfx[l+1][i] = sfx[l][i] | sfx[l][i + (1 << l)];
        end
      end
    end
  end

  // AND-OR reduction of the gated cell outputs
  always_comb begin
    nx_c         = 1'b0;
    pv_c         = 1'b0;
    pos_c        = '0;
    mrg_c        = '0;
    pred_start_c = '0;
    pred_size_c  = '0;
    rd_start_c   = '0;
    rd_size_c    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      nx_c         = nx_c | cell_flags[i].succ_hit;
      pv_c         = pv_c | cell_flags[i].pred_hit;
      pos_c        = pos_c | (cell_flags[i].last_lt ? (IDX_W + 1)'(i + 1) : '0);
      mrg_c        = mrg_c | cell_mrg_size[i];
      pred_start_c = pred_start_c | cell_pred_start[i];
      pred_size_c  = pred_size_c | cell_pred_size[i];
      rd_start_c   = rd_start_c | cell_rd_start[i];
      rd_size_c    = rd_size_c | cell_rd_size[i];
    end
  end

  // Capture the operation and search results
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func    <= func_t'(req.func);
      op_start   <= req.extent_start;
      op_size    <= req.extent_size;
      op_idx     <= req.entry_index;
      full       <= (cnt == CNT_W'(TABLE_DEPTH));
      bad        <= ((CNT_W + 1)'(req.entry_index) >= (CNT_W + 1)'(cnt));
      pos        <= pos_c[IDX_W-1:0];
      nx         <= nx_c;
      pv         <= pv_c;
      nsum       <= mrg_c;
      pred_start <= pred_start_c;
      pred_size  <= pred_size_c;
    end
  end

  // Predecessor absorbing the new extent (and its successor), saturated
  assign pred_grow  = (SZ_W + 1)'(pred_size) + (SZ_W + 1)'(nx ? nsum : op_size);
  assign pred_total = pred_grow[SZ_W] ? {SZ_W{1'b1}} : pred_grow[SZ_W-1:0];

  // Readout picks the indexed entry, or for a remove the entry that follows it
  assign rd_idx = (op_func == FUNC_REMOVE) ? (IDX_W + 1)'(op_idx) + (IDX_W + 1)'(1)
                                           : (IDX_W + 1)'(op_idx);

  // Update command and response
  always_comb begin
    mode_c    = UPD_NONE;
    upd_pos   = pos;
    upd_start = op_start;
    upd_size  = op_size;
    cnt_next  = cnt;
    r_status  = ST_OK;
    r_idx     = op_idx;
    r_nx      = 1'b0;
    r_pv      = 1'b0;
    r_start   = '0;
    r_size    = '0;
    case (op_func)
      FUNC_FREE: begin
        if (full) begin
          r_status = ST_FULL;
          r_idx    = '0;
        end else if (!nx && !pv) begin
          mode_c   = UPD_INSERT;
          cnt_next = cnt + CNT_W'(1);
          r_idx    = pos;
          r_start  = op_start;
          r_size   = op_size;
        end else if (nx && !pv) begin
          mode_c   = UPD_SET;
          upd_size = nsum;
          r_idx    = pos;
          r_nx     = 1'b1;
          r_start  = op_start;
          r_size   = nsum;
        end else begin
          mode_c   = nx ? UPD_SIZE_PULL : UPD_SIZE;
          upd_pos  = pos - IDX_W'(1);
          upd_size = pred_total;
          cnt_next = nx ? cnt - CNT_W'(1) : cnt;
          r_idx    = pos - IDX_W'(1);
          r_nx     = nx;
          r_pv     = 1'b1;
          r_start  = pred_start;
          r_size   = pred_total;
        end
      end
      FUNC_REMOVE: begin
        if (bad) begin
          r_status = ST_BAD_INDEX;
        end else begin
          mode_c   = UPD_REMOVE;
          upd_pos  = op_idx;
          cnt_next = cnt - CNT_W'(1);
          r_start  = rd_start_c;
          r_size   = rd_size_c;
        end
      end
      FUNC_WRITE: begin
        if (bad) begin
          r_status = ST_BAD_INDEX;
        end else begin
          mode_c  = UPD_SET;
          upd_pos = op_idx;
          r_start = op_start;
          r_size  = op_size;
        end
      end
      FUNC_READ: begin
        if (bad) begin
          r_status = ST_BAD_INDEX;
        end else begin
          r_start = rd_start_c;
          r_size  = rd_size_c;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, entry count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (fin) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (fin) begin
      out_status <= r_status;
      out_idx    <= r_idx;
      out_cnt    <= cnt_next;
      out_nx     <= r_nx;
      out_pv     <= r_pv;
      out_start  <= r_start;
      out_size   <= r_size;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_index = out_idx;
  assign rsp.entry_count  = out_cnt;
  assign rsp.merged_next  = out_nx;
  assign rsp.merged_prev  = out_pv;
  assign rsp.read_start   = out_start;
  assign rsp.read_size    = out_size;

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !fin |=> $stable(cnt))
    else $error("entry count changed outside the update cycle");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    fin && (op_func == FUNC_FREE) && !full && !nx && !pv
    |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("plain insert did not grow the table by one");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("response raised without an update cycle");

endmodule

FILE: src/sfet_cell.sv
// ----------------------------------------------------------------------------
// sfet_cell
// One table entry: holds start and size, evaluates the search key against
// its own entry, and shifts to or from its neighbors on update.
// ----------------------------------------------------------------------------
module sfet_cell
  import sfet_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int CELL_INDEX  = 0,
  localparam int IDX_W      = $clog2(TABLE_DEPTH),
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
  localparam int SZ_W       = ADDR_BITS + 1,
  localparam int END_W      = ADDR_BITS + 2
) (
  input  logic                 clk,
  input  logic [CNT_W-1:0]     count,
  // search key
  input  logic [ADDR_BITS-1:0] key_start,
  input  logic [SZ_W-1:0]      key_size,
  input  logic                 lt_left,
  input  logic                 tail_lt,
  // update command
  input  upd_mode_t            upd_mode,
  input  logic [IDX_W-1:0]     upd_pos,
  input  logic [ADDR_BITS-1:0] upd_start,
  input  logic [SZ_W-1:0]      upd_size,
  input  logic [ADDR_BITS-1:0] left_start,
  input  logic [SZ_W-1:0]      left_size,
  input  logic [ADDR_BITS-1:0] right_start,
  input  logic [SZ_W-1:0]      right_size,
  // readout select
  input  logic [IDX_W:0]       rd_idx,
  // stored entry and gated results
  output logic [ADDR_BITS-1:0] start,
  output logic [SZ_W-1:0]      size,
  output logic                 below_key,
  output cell_flags_t          flags,
  output logic [SZ_W-1:0]      mrg_size,
  output logic [ADDR_BITS-1:0] pred_start,
  output logic [SZ_W-1:0]      pred_size,
  output logic [ADDR_BITS-1:0] rd_start,
  output logic [SZ_W-1:0]      rd_size
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
  localparam logic [IDX_W:0]   MY_RD  = (IDX_W + 1)'(CELL_INDEX);

  logic [ADDR_BITS-1:0] ent_start, ent_start_next;
  logic [SZ_W-1:0]      ent_size, ent_size_next;
  logic                 valid, lt, mark;
  logic [END_W-1:0]     ent_end, key_end;
  logic [SZ_W:0]        grow;
  logic [SZ_W-1:0]      grow_sat;
  logic                 rd_hit;

  assign start = ent_start;
  assign size  = ent_size;

  // Search flags against the key (ends formed without wrap)
  assign valid   = MY_CNT < count;
  assign lt      = valid && (ent_start < key_start);
  assign mark    = lt_left && !lt && !tail_lt;
  assign ent_end = END_W'(ent_start) + END_W'(ent_size);
  assign key_end = END_W'(key_start) + END_W'(key_size);

  // lt on its own wire, free of the row-wide suffix term
  assign below_key = lt;

  assign flags.lt       = lt;
  assign flags.last_lt  = lt && !tail_lt;
  assign flags.succ_hit = mark && valid && (END_W'(ent_start) == key_end);
  assign flags.pred_hit = lt && !tail_lt && (ent_end == END_W'(key_start));

  // Key size absorbing this entry, saturated
  assign grow     = (SZ_W + 1)'(ent_size) + (SZ_W + 1)'(key_size);
  assign grow_sat = grow[SZ_W] ? {SZ_W{1'b1}} : grow[SZ_W-1:0];

  // Gated outputs, ORed across the row
  assign mrg_size   = flags.succ_hit ? grow_sat : '0;
  assign pred_start = flags.pred_hit ? ent_start : '0;
  assign pred_size  = flags.pred_hit ? ent_size : '0;

  assign rd_hit   = valid && (MY_RD == rd_idx);
  assign rd_start = rd_hit ? ent_start : '0;
  assign rd_size  = rd_hit ? ent_size : '0;

  // Entry update
  always_comb begin
    ent_start_next = ent_start;
    ent_size_next  = ent_size;
    case (upd_mode)
      UPD_INSERT: begin
        if (MY_IDX > upd_pos) begin
          ent_start_next = left_start;
          ent_size_next  = left_size;
        end else if (MY_IDX == upd_pos) begin
          ent_start_next = upd_start;
          ent_size_next  = upd_size;
        end
      end
      UPD_SET: begin
        if (MY_IDX == upd_pos) begin
          ent_start_next = upd_start;
          ent_size_next  = upd_size;
        end
      end
      UPD_SIZE: begin
        if (MY_IDX == upd_pos) begin
          ent_size_next = upd_size;
        end
      end
      UPD_SIZE_PULL: begin
        if (MY_IDX > upd_pos) begin
          ent_start_next = right_start;
          ent_size_next  = right_size;
        end else if (MY_IDX == upd_pos) begin
          ent_size_next = upd_size;
        end
      end
      UPD_REMOVE: begin
        if (MY_IDX >= upd_pos) begin
          ent_start_next = right_start;
          ent_size_next  = right_size;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_start <= ent_start_next;
    ent_size  <= ent_size_next;
  end

endmodule

FILE: verif/free_extent_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_extent_checker
// Watches the request and response channels of the free extent table. Every
// accepted request beat is applied to a shadow table and yields one predicted
// result; every accepted response beat is compared field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module free_extent_checker
  import sfet_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sfet_req_if  req,
  sfet_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding
);

  localparam int DEPTH      = DEF_TABLE_DEPTH;
  localparam int AW         = DEF_ADDR_BITS;

  typedef struct packed {
    status_t       status;
    logic [5:0]    result_index;
    logic [6:0]    entry_count;
    logic          merged_next;
    logic          merged_prev;
    logic [AW-1:0] read_start;
    logic [AW:0]   read_size;
  } extent_result_t;

  // Shadow of the extent table
  logic [AW-1:0]  shadow_start [DEPTH];
  logic [AW:0]    shadow_size  [DEPTH];
  int             shadow_count = 0;
  extent_result_t pending_results [$];
  int             error_total = 0;

  // Size sum that sticks at the field maximum
  function automatic logic [AW:0] sum_sizes(logic [AW:0] a, logic [AW:0] b);
    logic [AW+1:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AW+1] ? {(AW+1){1'b1}} : s[AW:0];
  endfunction

  // Close the gap left by one entry
  function automatic void drop_slot(int slot);
    int k;
    for (k = slot; k + 1 < shadow_count; k++) begin
      shadow_start[k] = shadow_start[k+1];
      shadow_size[k]  = shadow_size[k+1];
    end
    if (shadow_count > 0) shadow_count--;
  endfunction

  // Apply one operation to the shadow table and build its result
  function automatic extent_result_t apply_extent_op(func_t op, logic [AW-1:0] st,
                                                     logic [AW:0] sz, logic [5:0] slot);
    extent_result_t r;
    int pos;
    int k;
    r = '0;
    r.status = ST_OK;
    r.result_index = slot;
    if (op == FUNC_FREE) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
        r.result_index = '0;
      end else begin
        // insert after the highest entry that starts below the new one
        pos = shadow_count;
        while (pos > 0 && shadow_start[pos-1] >= st) pos--;
        for (k = shadow_count; k > pos; k--) begin
          shadow_start[k] = shadow_start[k-1];
          shadow_size[k]  = shadow_size[k-1];
        end
        shadow_start[pos] = st;
        shadow_size[pos]  = sz;
        shadow_count++;
        // absorb the successor; end address formed without wrap
        if (pos + 1 < shadow_count &&
            {2'b0, shadow_start[pos+1]} == {2'b0, st} + {1'b0, shadow_size[pos]}) begin
          shadow_size[pos] = sum_sizes(shadow_size[pos], shadow_size[pos+1]);
          drop_slot(pos + 1);
          r.merged_next = 1'b1;
        end
        // fold into the predecessor
        if (pos > 0 &&
            {2'b0, st} == {2'b0, shadow_start[pos-1]} + {1'b0, shadow_size[pos-1]}) begin
          shadow_size[pos-1] = sum_sizes(shadow_size[pos-1], shadow_size[pos]);
          drop_slot(pos);
          pos--;
          r.merged_prev = 1'b1;
        end
        r.result_index = pos[5:0];
        r.read_start   = shadow_start[pos];
        r.read_size    = shadow_size[pos];
      end
    end else if (int'(slot) >= shadow_count) begin
      r.status = ST_BAD_INDEX;
    end else if (op == FUNC_REMOVE) begin
      drop_slot(int'(slot));
      // readout is the entry that slid down, or zero past the end
      if (int'(slot) < shadow_count) begin
        r.read_start = shadow_start[slot];
        r.read_size  = shadow_size[slot];
      end
    end else begin
      if (op == FUNC_WRITE) begin
        shadow_start[slot] = st;
        shadow_size[slot]  = sz;
      end
      r.read_start = shadow_start[slot];
      r.read_size  = shadow_size[slot];
    end
    r.entry_count = shadow_count[6:0];
    return r;
  endfunction

  function automatic void cmp_field(string name, longint unsigned want,
                                    longint unsigned got);
    if (want != got) begin
      error_total++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
    end
  endfunction

  // Predict on request beats, compare on response beats
  always @(posedge clk) begin
    extent_result_t want;
    if (rst) begin
      shadow_count = 0;
      pending_results.delete();
    end else begin
      if (req.valid && req.ready)
        pending_results.push_back(apply_extent_op(func_t'(req.func), req.extent_start,
                                                  req.extent_size, req.entry_index));
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          error_total++;
          $display("%0t: unexpected result beat, expected none, actual status %0d index %0d",
                   $time, rsp.status, rsp.result_index);
        end else begin
          want = pending_results.pop_front();
          cmp_field("status",       want.status,       rsp.status);
          cmp_field("result_index", want.result_index, rsp.result_index);
          cmp_field("entry_count",  want.entry_count,  rsp.entry_count);
          cmp_field("merged_next",  want.merged_next,  rsp.merged_next);
          cmp_field("merged_prev",  want.merged_prev,  rsp.merged_prev);
          cmp_field("read_start",   want.read_start,   rsp.read_start);
          cmp_field("read_size",    want.read_size,    rsp.read_size);
        end
      end
    end
    mismatches  <= error_total;
    outstanding <= pending_results.size();
  end

endmodule

FILE: verif/tb_sorted_free_extent_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_free_extent_table_core
// Drives operations into the free extent table: a directed pass over the
// corner cases, a fill up to a full table and back to empty, then random
// rounds on a coarse address grid so that merges on both sides are frequent.
// Both channels stall in random bursts except in the closing round.
// ----------------------------------------------------------------------------
module tb_sorted_free_extent_table_core;
  import sfet_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int FILL_FREES     = 90;
  localparam int MAIN_ROUNDS    = 4;
  localparam int ROUND_OPS      = 330;
  localparam int FINAL_OPS      = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic idle_on = 1'b1;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles = 0;

  sfet_req_if req_ch ();
  sfet_rsp_if rsp_ch ();

  sorted_free_extent_table_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  free_extent_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One request beat, then maybe a burst of idle cycles
  task automatic send_op(func_t op, logic [15:0] st, logic [16:0] sz, logic [5:0] slot);
    int gap;
    @(negedge clk);
    req_ch.valid        = 1'b1;
    req_ch.func         = op;
    req_ch.extent_start = st;
    req_ch.extent_size  = sz;
    req_ch.entry_index  = slot;
    do @(posedge clk); while (!req_ch.ready);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly grid-aligned extents so neighbors touch often
  task automatic random_op();
    int sel;
    logic [15:0] st;
    logic [16:0] sz;
    logic [5:0] slot;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7) begin
      st = 16'($urandom_range(0, 63) * 16);
      sz = 17'($urandom_range(0, 3) * 16);
    end else if ($urandom_range(0, 2) != 0) begin
      st = 16'($urandom);
      sz = 17'($urandom_range(0, 65536));
    end else begin
      st = 16'($urandom);
      sz = 17'($urandom);
    end
    slot = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(0, 23));
    if (sel < 45)      send_op(FUNC_FREE,   st, sz, slot);
    else if (sel < 65) send_op(FUNC_REMOVE, st, sz, slot);
    else if (sel < 75) send_op(FUNC_WRITE,  st, sz, slot);
    else               send_op(FUNC_READ,   st, sz, slot);
  endtask

  // Response side: ready drops in random bursts while idling is on
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int n;
    int round;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_FREE;
    req_ch.extent_start = '0;
    req_ch.extent_size  = '0;
    req_ch.entry_index  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // bad index on an empty table
    send_op(FUNC_READ,   16'd0,     17'd0,       6'd0);
    send_op(FUNC_REMOVE, 16'd0,     17'd0,       6'd63);
    send_op(FUNC_WRITE,  16'hFFFF,  17'h1FFFF,   6'd5);
    // merges: none, with predecessor, with successor, with both
    send_op(FUNC_FREE,   16'd1000,  17'd100,     6'd0);
    send_op(FUNC_FREE,   16'hFFFF,  17'h10000,   6'd0);
    send_op(FUNC_FREE,   16'd1100,  17'd50,      6'd0);
    send_op(FUNC_FREE,   16'd900,   17'd100,     6'd0);
    send_op(FUNC_FREE,   16'd1150,  17'd64385,   6'd0);
    // zero sizes and an equal start that lands in front
    send_op(FUNC_FREE,   16'd0,     17'd0,       6'd0);
    send_op(FUNC_FREE,   16'd0,     17'd0,       6'd0);
    // oversized entry, then a successor merge that saturates
    send_op(FUNC_WRITE,  16'd500,   17'h1FFFF,   6'd1);
    send_op(FUNC_FREE,   16'd400,   17'd100,     6'd0);
    // ends that only match modulo the address range must not merge
    send_op(FUNC_FREE,   16'h01A0,  17'h10100,   6'd0);
    send_op(FUNC_FREE,   16'h02A0,  17'd1,       6'd0);
    send_op(FUNC_FREE,   16'h02A0,  17'h10000,   6'd0);
    // reads, removal of the last entry and of the first
    send_op(FUNC_READ,   16'd0,     17'd0,       6'd4);
    send_op(FUNC_READ,   16'd0,     17'd0,       6'd5);
    send_op(FUNC_REMOVE, 16'd0,     17'd0,       6'd4);
    send_op(FUNC_REMOVE, 16'd0,     17'd0,       6'd0);
    send_op(FUNC_WRITE,  16'hFFFF,  17'd0,       6'd2);
    send_op(FUNC_READ,   16'd0,     17'd0,       6'd63);
    wait_drained();

    // fill with scattered small extents until the table is full
    for (n = 0; n < FILL_FREES; n++) begin
      send_op(FUNC_FREE, 16'($urandom), 17'($urandom_range(0, 7)), 6'($urandom));
      if (n % 10 == 9)
        send_op(FUNC_READ, 16'($urandom), 17'($urandom), 6'($urandom_range(0, 63)));
    end
    for (n = 0; n < 24; n++) begin
      case (n % 3)
        0: send_op(FUNC_WRITE, 16'($urandom), 17'($urandom), 6'($urandom_range(0, 63)));
        1: send_op(FUNC_FREE,  16'($urandom), 17'($urandom), 6'($urandom));
        default: send_op(FUNC_READ, 16'($urandom), 17'($urandom), 6'($urandom_range(0, 63)));
      endcase
    end
    send_op(FUNC_REMOVE, 16'd0, 17'd0, 6'd63);
    send_op(FUNC_REMOVE, 16'd0, 17'd0, 6'd0);
    wait_drained();

    // empty the table and keep removing past empty
    for (n = 0; n < 70; n++)
      send_op(FUNC_REMOVE, 16'($urandom), 17'($urandom), 6'($urandom_range(0, 3)));
    wait_drained();

    // random rounds with a full drain between them
    for (round = 0; round < MAIN_ROUNDS; round++) begin
      for (n = 0; n < ROUND_OPS; n++)
        random_op();
      wait_drained();
    end

    // closing round at full rate on both sides
    idle_on = 1'b0;
    for (n = 0; n < FINAL_OPS; n++)
      random_op();
    wait_drained();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
